### rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types and constants of the eeprom byte master: beat payloads,
// configuration register set, sequencer phase codes
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd2;

  // reset values of the configuration registers
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
  localparam logic [7:0] PHASE_TICKS_RST    = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  // command codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // byte stages of a transfer
  localparam logic [1:0] STAGE_DEV  = 2'd0;
  localparam logic [1:0] STAGE_ADDR = 2'd1;
  localparam logic [1:0] STAGE_DATA = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  // bus phase of the sequencer
  typedef enum logic [15:0] {
    KIND_IDLE = 16'h0001,
    KIND_ST0  = 16'h0002,
    KIND_ST1  = 16'h0004,
    KIND_ST2  = 16'h0008,
    KIND_ST3  = 16'h0010,
    KIND_BLO  = 16'h0020,
    KIND_BHI  = 16'h0040,
    KIND_ALO  = 16'h0080,
    KIND_AHI  = 16'h0100,
    KIND_RLO  = 16'h0200,
    KIND_RHI  = 16'h0400,
    KIND_NLO  = 16'h0800,
    KIND_NHI  = 16'h1000,
    KIND_SP0  = 16'h2000,
    KIND_SP1  = 16'h4000,
    KIND_SP2  = 16'h8000
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] stage;
  } seq_stat_t;

endpackage

`default_nettype wire

### rtl/i2cee_cfg.sv
// ----------------------------------------------------------------------------
// i2cee_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output i2cee_pkg::cfg_t          cfg
);
  import i2cee_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg_nxt.device_address = cfg_data[6:0];
        CFG_PHASE_TICKS:    cfg_nxt.phase_ticks    = cfg_data;
        CFG_ACK_TIMEOUT:    cfg_nxt.ack_timeout    = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.phase_ticks    <= PHASE_TICKS_RST;
      cfg_r.ack_timeout    <= ACK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/i2cee_seq.sv
// ----------------------------------------------------------------------------
// i2cee_seq
// bus sequencer: one tick per step, result beat formed combinationally
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  i2cee_pkg::in_item_t       item,
  input  i2cee_pkg::cfg_t           cfg,
  output i2cee_pkg::out_item_t      res,
  output i2cee_pkg::seq_stat_t      stat
);
  import i2cee_pkg::*;

  kind_t      kind_r,   kind_nxt;
  logic [1:0] stage_r,  stage_nxt;
  logic [7:0] pc_r,     pc_nxt;
  logic [3:0] bc_r,     bc_nxt;
  logic [7:0] sr_r,     sr_nxt;
  logic [7:0] wc_r,     wc_nxt;
  logic       rd_r,     rd_nxt;
  logic [7:0] addr_r,   addr_nxt;
  logic [7:0] data_r,   data_nxt;
  logic [7:0] rx_r,     rx_nxt;
  logic       err_r,    err_nxt;

  logic       start;
  kind_t      kind_c;
  logic [1:0] stage_c;
  logic [7:0] pc_c, sr_c, wc_c;
  logic [3:0] bc_c;
  logic [7:0] ticks;
  logic [7:0] pc_inc, wc_inc;
  logic [3:0] bc_inc;
  logic       pend;
  logic       scl, rel, busy, done;

  assign start = (kind_r == KIND_IDLE) &&
                 ((item.operation == OP_WRITE) || (item.operation == OP_READ));

  // values after a command is taken
  assign kind_c  = start ? KIND_ST0 : kind_r;
  assign stage_c = start ? STAGE_DEV : stage_r;
  assign pc_c    = start ? 8'd0 : pc_r;
  assign bc_c    = start ? 4'd0 : bc_r;
  assign sr_c    = start ? 8'd0 : sr_r;
  assign wc_c    = start ? 8'd0 : wc_r;

  assign ticks  = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign pc_inc = pc_c + 8'd1;
  assign pend   = (pc_inc >= ticks);
  assign wc_inc = wc_c + 8'd1;
  assign bc_inc = bc_c + 4'd1;

  always_comb begin
    kind_nxt  = kind_c;
    stage_nxt = stage_c;
    pc_nxt    = pc_c;
    bc_nxt    = bc_c;
    sr_nxt    = sr_c;
    wc_nxt    = wc_c;
    rd_nxt    = start ? (item.operation == OP_READ) : rd_r;
    addr_nxt  = start ? item.mem_address : addr_r;
    data_nxt  = start ? item.write_data : data_r;
    rx_nxt    = rx_r;
    err_nxt   = start ? 1'b0 : err_r;
    scl       = 1'b1;
    rel       = 1'b1;
    busy      = (kind_c != KIND_IDLE);
    done      = 1'b0;

    case (kind_c)
      KIND_IDLE: begin
        busy = 1'b0;
      end
      KIND_ST0: begin
        scl = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_ST1;
      end
      KIND_ST1: begin
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_ST2;
      end
      KIND_ST2: begin
        rel = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_ST3;
      end
      KIND_ST3: begin
        scl = 1'b0;
        rel = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          // address byte with r/w bit; read only after the repeated start
          sr_nxt   = {cfg.device_address, (stage_c != STAGE_DEV)};
          bc_nxt   = 4'd0;
          kind_nxt = KIND_BLO;
        end
      end
      KIND_BLO: begin
        scl = 1'b0;
        rel = sr_c[7];
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_BHI;
      end
      KIND_BHI: begin
        rel = sr_c[7];
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          sr_nxt = {sr_c[6:0], 1'b0};
          if (bc_inc >= BITS_PER_BYTE) begin
            bc_nxt   = 4'd0;
            kind_nxt = KIND_ALO;
          end else begin
            bc_nxt   = bc_inc;
            kind_nxt = KIND_BLO;
          end
        end
      end
      KIND_ALO: begin
        scl = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          wc_nxt   = 8'd0;
          kind_nxt = KIND_AHI;
        end
      end
      KIND_AHI: begin
        // hold the high phase, then watch for the slave pulling sda low
        if (({1'b0, pc_c} + 9'd1) < {1'b0, ticks}) begin
          pc_nxt = pc_inc;
        end else if (!item.sda_in) begin
          pc_nxt = 8'd0;
          wc_nxt = 8'd0;
          case (stage_c)
            STAGE_DEV: begin
              sr_nxt    = addr_r;
              stage_nxt = STAGE_ADDR;
              kind_nxt  = KIND_BLO;
            end
            STAGE_ADDR: begin
              stage_nxt = STAGE_DATA;
              if (rd_r) begin
                kind_nxt = KIND_ST0;
              end else begin
                sr_nxt   = data_r;
                kind_nxt = KIND_BLO;
              end
            end
            default: begin
              if (rd_r) begin
                sr_nxt    = 8'd0;
                bc_nxt    = 4'd0;
                stage_nxt = STAGE_DATA;
                kind_nxt  = KIND_RLO;
              end else begin
                stage_nxt = STAGE_DEV;
                kind_nxt  = KIND_SP0;
              end
            end
          endcase
        end else begin
          wc_nxt = wc_inc;
          if (wc_inc >= cfg.ack_timeout) begin
            err_nxt   = 1'b1;
            pc_nxt    = 8'd0;
            wc_nxt    = 8'd0;
            stage_nxt = STAGE_DEV;
            kind_nxt  = KIND_SP0;
          end
        end
      end
      KIND_RLO: begin
        scl = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_RHI;
      end
      KIND_RHI: begin
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          sr_nxt = {sr_c[6:0], item.sda_in};
          if (bc_inc >= BITS_PER_BYTE) begin
            bc_nxt   = 4'd0;
            rx_nxt   = {sr_c[6:0], item.sda_in};
            kind_nxt = KIND_NLO;
          end else begin
            bc_nxt   = bc_inc;
            kind_nxt = KIND_RLO;
          end
        end
      end
      KIND_NLO: begin
        scl = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_NHI;
      end
      KIND_NHI: begin
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          stage_nxt = STAGE_DEV;
          kind_nxt  = KIND_SP0;
        end
      end
      KIND_SP0: begin
        scl = 1'b0;
        rel = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_SP1;
      end
      KIND_SP1: begin
        rel = 1'b0;
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) kind_nxt = KIND_SP2;
      end
      KIND_SP2: begin
        pc_nxt = pend ? 8'd0 : pc_inc;
        if (pend) begin
          kind_nxt = KIND_IDLE;
          done     = 1'b1;
        end
      end
      default: begin
        kind_nxt = KIND_IDLE;
        pc_nxt   = 8'd0;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_IDLE;
      stage_r <= STAGE_DEV;
      pc_r    <= 8'd0;
      bc_r    <= 4'd0;
      sr_r    <= 8'd0;
      wc_r    <= 8'd0;
      rd_r    <= 1'b0;
      addr_r  <= 8'd0;
      data_r  <= 8'd0;
      rx_r    <= 8'd0;
      err_r   <= 1'b0;
    end else if (step) begin
      kind_r  <= kind_nxt;
      stage_r <= stage_nxt;
      pc_r    <= pc_nxt;
      bc_r    <= bc_nxt;
      sr_r    <= sr_nxt;
      wc_r    <= wc_nxt;
      rd_r    <= rd_nxt;
      addr_r  <= addr_nxt;
      data_r  <= data_nxt;
      rx_r    <= rx_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    res.scl_out     = scl;
    res.sda_release = rel;
    res.busy_res    = busy;
    res.done_res    = done;
    res.read_data   = rx_nxt;
    res.ack_error   = err_nxt;
  end

  assign stat.kind  = kind_r;
  assign stat.stage = stage_r;

endmodule

`default_nettype wire

### rtl/i2c_eeprom_byte_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// i2c master for a serial eeprom: single byte write and random byte read,
// advanced one bus tick per input beat
// ----------------------------------------------------------------------------
//
//   channel   ports                        beat
//   in        in_valid / in_stall          in_item   : command and sda sample
//   out       out_valid / out_stall        out_item  : scl, sda, status, data
//   cfg       cfg_we / cfg_index           cfg_data  : register write
//
// one tick beat in, one result beat out; a new beat every cycle unless
// the output stalls; a beat goes through the input register, then the
// sequencer step into the result register
// the input register doubles as a skid stage, so a beat is still taken
// while a finished result waits on a stalled output
// synchronous active-low reset returns the sequencer to idle and the
// configuration and valid registers to their defaults; payloads are not reset
//
`default_nettype none

module i2c_eeprom_byte_master (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  i2cee_pkg::in_item_t        in_item,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output i2cee_pkg::out_item_t       out_item,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import i2cee_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic      s1_go;      // result register can take a beat
  logic      in_acc;     // input beat taken
  logic      seq_step;   // sequencer advances one tick
  cfg_t      cfg;
  out_item_t seq_res;
  seq_stat_t seq_stat;

  // handshake
  assign s1_go    = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign seq_step = s1_valid_r && s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (seq_step) begin
      s1_valid_nxt = 1'b0;
    end
    // result held while stalled, replaced when the sequencer steps
    out_valid_nxt = seq_step || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (seq_step) begin
      out_item_r <= seq_res;
    end
  end

  i2cee_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cee_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (seq_step),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (seq_res),
    .stat  (seq_stat)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // sequencer only moves when a beat is processed
  a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_step |=> $stable(seq_stat.kind) && $stable(seq_stat.stage))
    else $error("sequencer moved without a beat");

  // a held input beat is not lost while the output is blocked
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_item_r))
    else $error("buffered input beat dropped");

  // end of a transfer is always flagged as part of it
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_step && seq_res.done_res |-> seq_res.busy_res)
    else $error("done without busy");

  // idle sequencer drives the bus released
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    seq_step && !seq_res.busy_res |-> seq_res.scl_out && seq_res.sda_release)
    else $error("bus driven while idle");

endmodule

`default_nettype wire

### tb/tb_i2c_eeprom_byte_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_master
// self-checking bench for the eeprom byte master: every tick beat is scored
// against a cycle-true model of the bus sequencer kept in the bench, with a
// slave on the sda side that acknowledges, returns random data or refuses
// ----------------------------------------------------------------------------

module tb_i2c_eeprom_byte_master;
  import i2cee_pkg::*;

  // spare command code, behaves as a plain tick
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 4;        // two-stage pipe plus margin
  localparam int HOLD_CYCLES   = 64;       // long receiver hold-off
  localparam int CYCLE_LIMIT   = 500000;

  // bus levels with nothing going on, and on the first tick of a command
  localparam out_item_t BUS_IDLE  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t BUS_START = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  i2c_eeprom_byte_master i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // bench copy of the sequencer: registers, phase, counters, latches
  // --------------------------------------------------------------------------
  cfg_t       bus_cfg   = '{DEVICE_ADDRESS_RST, PHASE_TICKS_RST, ACK_TIMEOUT_RST};
  kind_t      seq_kind  = KIND_IDLE;
  logic [1:0] seq_stage = STAGE_DEV;
  logic [7:0] tick_cnt  = '0;
  logic [3:0] bit_cnt   = '0;
  logic [7:0] shreg     = '0;
  logic [7:0] ack_wait  = '0;
  logic       rd_mode   = 1'b0;
  logic [7:0] addr_hold = '0;
  logic [7:0] data_hold = '0;
  logic [7:0] rx_byte   = '0;
  logic       err_flag  = 1'b0;

  // results still owed by the block, oldest first
  out_item_t bus_expected [$];

  int  errors         = 0;
  int  cycle_count    = 0;
  int  send_gap_pct   = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  hold_left      = 0;
  bit  slave_acks     = 1'b1;
  out_item_t oldest_want;

  // advance the phase counter, true on the last tick of a phase
  // a zero phase length counts as one tick
  function automatic bit phase_done();
    logic [7:0] span;
    span = (bus_cfg.phase_ticks == 8'd0) ? 8'd1 : bus_cfg.phase_ticks;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= span) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one bus tick: take a command if idle, step the phase, return the beat
  function automatic out_item_t bus_step(in_item_t it);
    out_item_t  r;
    logic [7:0] span;
    r = BUS_IDLE;
    span = (bus_cfg.phase_ticks == 8'd0) ? 8'd1 : bus_cfg.phase_ticks;

    // commands only land while idle; a new one wipes the old error
    if (seq_kind == KIND_IDLE && (it.operation == OP_WRITE || it.operation == OP_READ)) begin
      rd_mode   = (it.operation == OP_READ);
      addr_hold = it.mem_address;
      data_hold = it.write_data;
      err_flag  = 1'b0;
      seq_kind  = KIND_ST0;
      seq_stage = STAGE_DEV;
      tick_cnt  = '0;
      bit_cnt   = '0;
      ack_wait  = '0;
      shreg     = '0;
    end

    if (seq_kind != KIND_IDLE) begin
      r.busy_res = 1'b1;
      case (seq_kind)
        // start condition, also used for the repeated start
        KIND_ST0: begin
          r.scl_out = 1'b0;
          if (phase_done()) seq_kind = KIND_ST1;
        end
        KIND_ST1: begin
          if (phase_done()) seq_kind = KIND_ST2;
        end
        KIND_ST2: begin
          r.sda_release = 1'b0;
          if (phase_done()) seq_kind = KIND_ST3;
        end
        KIND_ST3: begin
          r.scl_out = 1'b0;
          r.sda_release = 1'b0;
          if (phase_done()) begin
            // read bit set on any address byte after the first stage
            shreg   = {bus_cfg.device_address, seq_stage != STAGE_DEV};
            bit_cnt = '0;
            seq_kind = KIND_BLO;
          end
        end
        // byte out, msb first
        KIND_BLO: begin
          r.scl_out = 1'b0;
          r.sda_release = shreg[7];
          if (phase_done()) seq_kind = KIND_BHI;
        end
        KIND_BHI: begin
          r.sda_release = shreg[7];
          if (phase_done()) begin
            shreg   = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              bit_cnt  = '0;
              seq_kind = KIND_ALO;
            end else begin
              seq_kind = KIND_BLO;
            end
          end
        end
        KIND_ALO: begin
          r.scl_out = 1'b0;
          if (phase_done()) begin
            ack_wait = '0;
            seq_kind = KIND_AHI;
          end
        end
        // ack: hold the high phase, then watch sda until low or timeout
        KIND_AHI: begin
          if ({1'b0, tick_cnt} + 9'd1 < {1'b0, span}) begin
            tick_cnt = tick_cnt + 8'd1;
          end else if (!it.sda_in) begin
            tick_cnt = '0;
            ack_wait = '0;
            if (seq_stage == STAGE_DEV) begin
              shreg     = addr_hold;
              seq_stage = STAGE_ADDR;
              seq_kind  = KIND_BLO;
            end else if (seq_stage == STAGE_ADDR) begin
              seq_stage = STAGE_DATA;
              if (rd_mode) begin
                seq_kind = KIND_ST0;
              end else begin
                shreg    = data_hold;
                seq_kind = KIND_BLO;
              end
            end else if (rd_mode) begin
              shreg    = '0;
              bit_cnt  = '0;
              seq_kind = KIND_RLO;
            end else begin
              seq_stage = STAGE_DEV;
              seq_kind  = KIND_SP0;
            end
          end else begin
            ack_wait = ack_wait + 8'd1;
            if (ack_wait >= bus_cfg.ack_timeout) begin
              err_flag  = 1'b1;
              tick_cnt  = '0;
              ack_wait  = '0;
              seq_stage = STAGE_DEV;
              seq_kind  = KIND_SP0;
            end
          end
        end
        // byte in, sampled on the last high tick
        KIND_RLO: begin
          r.scl_out = 1'b0;
          if (phase_done()) seq_kind = KIND_RHI;
        end
        KIND_RHI: begin
          if (phase_done()) begin
            shreg   = {shreg[6:0], it.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              bit_cnt  = '0;
              rx_byte  = shreg;
              seq_kind = KIND_NLO;
            end else begin
              seq_kind = KIND_RLO;
            end
          end
        end
        // nack after the read byte
        KIND_NLO: begin
          r.scl_out = 1'b0;
          if (phase_done()) seq_kind = KIND_NHI;
        end
        KIND_NHI: begin
          if (phase_done()) begin
            seq_stage = STAGE_DEV;
            seq_kind  = KIND_SP0;
          end
        end
        // stop condition
        KIND_SP0: begin
          r.scl_out = 1'b0;
          r.sda_release = 1'b0;
          if (phase_done()) seq_kind = KIND_SP1;
        end
        KIND_SP1: begin
          r.sda_release = 1'b0;
          if (phase_done()) seq_kind = KIND_SP2;
        end
        KIND_SP2: begin
          if (phase_done()) begin
            seq_kind   = KIND_IDLE;
            seq_stage  = STAGE_DEV;
            r.done_res = 1'b1;
          end
        end
        default: begin
          seq_kind   = KIND_IDLE;
          seq_stage  = STAGE_DEV;
          tick_cnt   = '0;
          r.done_res = 1'b1;
        end
      endcase
    end

    r.read_data = rx_byte;
    r.ack_error = err_flag;
    return r;
  endfunction

  // next tick beat, shaped by where the sequencer stands
  // settle: plain ticks and a slave that always acks, to run a transfer out
  function automatic in_item_t make_tick(bit settle);
    in_item_t it;
    int       pick;
    it.mem_address = 8'($urandom);
    it.write_data  = 8'($urandom);
    it.sda_in      = 1'($urandom_range(0, 1));
    if (settle) begin
      it.operation = OP_TICK;
    end else if (seq_kind != KIND_IDLE) begin
      // anything while busy is ignored by the block
      it.operation = 2'($urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      it.operation = OP_WRITE;
      else if (pick < 8) it.operation = OP_READ;
      else if (pick < 9) it.operation = OP_TICK;
      else               it.operation = OP_SPARE;
      // most slaves answer, some never do
      if (pick < 8) slave_acks = ($urandom_range(0, 99) < 85);
    end
    // ack window: low to acknowledge, now and then a late high sample
    if (seq_kind == KIND_AHI) begin
      if (settle)          it.sda_in = 1'b0;
      else if (slave_acks) it.sda_in = ($urandom_range(0, 7) == 0);
      else                 it.sda_in = 1'b1;
    end
    return it;
  endfunction

  // offer one beat and return at the edge that takes it
  task automatic send_tick(in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // run the current transfer out, then let the pipe empty
  task automatic finish_transfer();
    in_item_t it;
    while (seq_kind != KIND_IDLE) begin
      it = make_tick(1'b1);
      send_tick(it);
      bus_expected.push_back(bus_step(it));
    end
    in_valid <= 1'b0;
    while (bus_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers on consecutive edges
  task automatic program_regs(logic [6:0] dev, logic [7:0] ticks, logic [7:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= {1'b0, dev};
    @(posedge clk);
    cfg_index <= CFG_PHASE_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    bus_cfg = '{dev, ticks, tmo};
  endtask

  // --------------------------------------------------------------------------
  // directed beats at reset settings; typed results only where obvious
  // --------------------------------------------------------------------------
  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } check_row_t;

  check_row_t opening_rows [12] = '{
    '{'{OP_TICK,  8'h00, 8'h00, 1'b0}, 1'b1, BUS_IDLE},   // plain tick after reset
    '{'{OP_SPARE, 8'hFF, 8'hFF, 1'b1}, 1'b1, BUS_IDLE},   // spare code is a tick
    '{'{OP_TICK,  8'hFF, 8'hFF, 1'b1}, 1'b1, BUS_IDLE},
    '{'{OP_WRITE, 8'hFF, 8'h00, 1'b1}, 1'b1, BUS_START},  // write starts at once
    '{'{OP_READ,  8'h00, 8'hFF, 1'b0}, 1'b0, BUS_IDLE},   // command while busy
    '{'{OP_WRITE, 8'h55, 8'hAA, 1'b1}, 1'b0, BUS_IDLE},
    '{'{OP_SPARE, 8'hAA, 8'h55, 1'b0}, 1'b0, BUS_IDLE},
    '{'{OP_TICK,  8'h80, 8'h01, 1'b1}, 1'b0, BUS_IDLE},
    '{'{OP_READ,  8'h01, 8'h80, 1'b0}, 1'b0, BUS_IDLE},
    '{'{OP_TICK,  8'h7F, 8'hFE, 1'b1}, 1'b0, BUS_IDLE},
    '{'{OP_WRITE, 8'hFE, 8'h7F, 1'b0}, 1'b0, BUS_IDLE},
    '{'{OP_TICK,  8'h00, 8'hFF, 1'b0}, 1'b0, BUS_IDLE}
  };

  // --------------------------------------------------------------------------
  // random phases: register setting, idling on each side, beat count
  // each phase also runs its last transfer out, which adds beats
  // --------------------------------------------------------------------------
  typedef struct {
    logic [6:0] dev;
    logic [7:0] ticks;
    logic [7:0] tmo;
    int         gap;
    int         stall;
    int         beats;
    bit         squeeze;
  } plan_row_t;

  plan_row_t plan [6] = '{
    '{7'd127, 8'd1,   8'd3,   0,  0,  50, 1'b0},  // top address, fast bus
    '{7'd0,   8'd0,   8'd0,   79, 0,  30, 1'b0},  // zero phase and timeout
    '{7'h2A,  8'd1,   8'd255, 0,  79, 30, 1'b0},  // longest ack wait
    '{7'd80,  8'd1,   8'd1,   26, 26, 30, 1'b0},  // one high sample aborts
    '{7'h55,  8'd2,   8'd2,   0,  0,  20, 1'b0},  // slower bus
    '{7'd1,   8'd2,   8'd8,   0,  0,  40, 1'b1}   // receiver holds off
  };

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall, long hold-off on request, score each beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_expected.size() == 0) begin
        $error("result beat with nothing expected: %h", out_item);
        errors++;
      end else begin
        oldest_want = bus_expected.pop_front();
        if (out_item.scl_out !== oldest_want.scl_out) begin
          $error("scl_out expected %0d got %0d", oldest_want.scl_out, out_item.scl_out);
          errors++;
        end
        if (out_item.sda_release !== oldest_want.sda_release) begin
          $error("sda_release expected %0d got %0d",
                 oldest_want.sda_release, out_item.sda_release);
          errors++;
        end
        if (out_item.busy_res !== oldest_want.busy_res) begin
          $error("busy_res expected %0d got %0d", oldest_want.busy_res, out_item.busy_res);
          errors++;
        end
        if (out_item.done_res !== oldest_want.done_res) begin
          $error("done_res expected %0d got %0d", oldest_want.done_res, out_item.done_res);
          errors++;
        end
        if (out_item.read_data !== oldest_want.read_data) begin
          $error("read_data expected %h got %h", oldest_want.read_data, out_item.read_data);
          errors++;
        end
        if (out_item.ack_error !== oldest_want.ack_error) begin
          $error("ack_error expected %0d got %0d", oldest_want.ack_error, out_item.ack_error);
          errors++;
        end
      end
    end

    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_item_t  it;
    out_item_t guess;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEVICE_ADDRESS;
    cfg_data  = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening, model stepped on every row to keep it in line
    foreach (opening_rows[i]) begin
      send_tick(opening_rows[i].stim);
      guess = bus_step(opening_rows[i].stim);
      bus_expected.push_back(opening_rows[i].known ? opening_rows[i].want : guess);
    end
    finish_transfer();

    // random phases; each ends with the sequencer idle and the pipe empty
    foreach (plan[p]) begin
      program_regs(plan[p].dev, plan[p].ticks, plan[p].tmo);
      send_gap_pct   = plan[p].gap;
      recv_stall_pct = plan[p].stall;
      // sender keeps offering through the hold-off so the input backs up
      if (plan[p].squeeze) hold_req = 1'b1;
      repeat (plan[p].beats) begin
        it = make_tick(1'b0);
        send_tick(it);
        bus_expected.push_back(bus_step(it));
      end
      finish_transfer();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
